// ----- hdl/tea_block_cipher_top_macros.svh -----
// Assertion macros for the TEA block cipher RTL.
// Used by tea_block_cipher_top.sv; no other dependencies.
`ifndef TEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define TEA_BLOCK_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tbc assertion failed");

`endif

// ----- hdl/tbc_pkg.sv -----
// Shared types and constants for the TEA block cipher.
// No dependencies.
`default_nettype none

package tbc_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned ROUND_COUNT = 32;
	localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;   // one half-round per stage
	localparam int unsigned KEY_COUNT   = 4;
	localparam int unsigned KEY_IDX_W   = $clog2(KEY_COUNT);

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [KEY_IDX_W-1:0] {
		KEY_W0 = 2'd0,
		KEY_W1 = 2'd1,
		KEY_W2 = 2'd2,
		KEY_W3 = 2'd3
	} key_idx_t;

	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	// One item in flight.
	typedef struct packed {
		cmd_t  cmd;
		word_t left;
		word_t right;
	} stage_t;

	// Running sum after a number of delta steps, modulo 2^32.
	function automatic word_t round_sum(input int unsigned steps);
		logic [2*WORD_W-1:0] prod;
		prod = 64'(steps) * 64'(TEA_DELTA);
		return prod[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tea_block_cipher_top.sv -----
// TEA block cipher top level: fully unrolled half-round pipeline.
// Depends on tbc_pkg.sv and tea_block_cipher_top_macros.svh.
//
// Usage
//   cfg channel : cfg_valid/cfg_ready with cfg_index (0..3 -> key words k0..k3)
//                 and cfg_data. cfg_ready is always high. Write keys only while
//                 the pipeline is empty; the key feeds every stage directly.
//   s_ side     : one beat = one 64-bit block. tdata = {right_in, left_in},
//                 tuser = command (0 encrypt, 1 decrypt).
//   m_ side     : one beat = one result, tdata = {right_out, left_out}.
//   Stages      : 64 register stages, one TEA half-round (three 32-bit adds and
//                 two xors for the mix, then an add or subtract) per stage. A
//                 block enters stage 0 and shows on m_tvalid from stage 63.
//   Throughput  : one block per cycle when not stalled, set by the per-stage
//                 valid/enable chain; encrypt and decrypt beats mix freely.
//   Stall       : each stage loads when it is empty or the stage after it moves,
//                 so bubbles squeeze out while m_tready is low and s_tready only
//                 drops once all 64 stages hold a block.
//   Reset       : arst_n clears all stage valid bits and the key (all zero).
`default_nettype none

`include "tea_block_cipher_top_macros.svh"

module tea_block_cipher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// input blocks
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] left_in, [63:32] right_in
	input  wire logic        s_tuser,   // [0] command
	// result blocks
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // [31:0] left_out, [63:32] right_out
);

	localparam int unsigned N = tbc_pkg::STAGE_COUNT;

	// key words
	tbc_pkg::word_t key_q [tbc_pkg::KEY_COUNT];

	// pipeline
	logic             pipe_v_s [N];
	tbc_pkg::stage_t  pipe_d_s [N];
	tbc_pkg::stage_t  stage_in [N];   // what feeds each stage register
	tbc_pkg::stage_t  stage_nx [N];   // after that stage's half-round
	logic             en       [N];   // stage register may load
	logic             v_in     [N];

	// mix term: ((x<<4)+ka) ^ (x+sum) ^ ((x>>5)+kb)
	function automatic tbc_pkg::word_t tea_mix(
		input tbc_pkg::word_t x,
		input tbc_pkg::word_t sum,
		input tbc_pkg::word_t ka,
		input tbc_pkg::word_t kb
	);
		tbc_pkg::word_t t0, t1, t2;
		t0 = (x << 4) + ka;
		t1 = x + sum;
		t2 = (x >> 5) + kb;
		return t0 ^ t1 ^ t2;
	endfunction

	// ---------------- config ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbc_pkg::KEY_COUNT; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (tbc_pkg::key_idx_t'(cfg_index))
				tbc_pkg::KEY_W0: key_q[0] <= cfg_data;
				tbc_pkg::KEY_W1: key_q[1] <= cfg_data;
				tbc_pkg::KEY_W2: key_q[2] <= cfg_data;
				tbc_pkg::KEY_W3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline ----------------
	assign stage_in[0] = '{cmd:   tbc_pkg::cmd_t'(s_tuser),
	                       left:  s_tdata[31:0],
	                       right: s_tdata[63:32]};
	assign v_in[0]     = s_tvalid;
	assign s_tready    = en[0];

	assign en[N-1] = !pipe_v_s[N-1] || m_tready;

	for (genvar j = 0; j < N; j++) begin : g_stage
		// Encrypt runs rounds 0..R-1 with sum = (r+1)*delta; decrypt runs them
		// backwards with sum = (R-r)*delta. In each half-round the word that is
		// updated and the key pair flip together with the direction.
		localparam int unsigned   RND     = j >> 1;
		localparam logic          HALF    = 1'(j & 1);
		localparam tbc_pkg::word_t SUM_ENC = tbc_pkg::round_sum(RND + 1);
		localparam tbc_pkg::word_t SUM_DEC = tbc_pkg::round_sum(tbc_pkg::ROUND_COUNT - RND);

		logic           dec;
		logic           upd_left;
		tbc_pkg::word_t sum, x, y, ka, kb, m, y_new;

		if (j > 0) begin : g_link
			assign stage_in[j] = pipe_d_s[j-1];
			assign v_in[j]     = pipe_v_s[j-1];
		end
		if (j < N - 1) begin : g_en
			assign en[j] = !pipe_v_s[j] || en[j+1];
		end

		always_comb begin
			dec      = (stage_in[j].cmd == tbc_pkg::CMD_DECRYPT);
			upd_left = (dec == HALF);
			sum      = dec ? SUM_DEC : SUM_ENC;
			x        = upd_left ? stage_in[j].right : stage_in[j].left;
			y        = upd_left ? stage_in[j].left  : stage_in[j].right;
			ka       = upd_left ? key_q[0] : key_q[2];
			kb       = upd_left ? key_q[1] : key_q[3];
			m        = tea_mix(x, sum, ka, kb);
			y_new    = dec ? (y - m) : (y + m);

			stage_nx[j]       = stage_in[j];
			stage_nx[j].left  = upd_left ? y_new : stage_in[j].left;
			stage_nx[j].right = upd_left ? stage_in[j].right : y_new;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_v_s[j] <= 1'b0;
			end else if (en[j]) begin
				pipe_v_s[j] <= v_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				pipe_d_s[j] <= stage_nx[j];
			end
		end
	end

	assign m_tvalid = pipe_v_s[N-1];
	assign m_tdata  = {pipe_d_s[N-1].right, pipe_d_s[N-1].left};

	// ---------------- checks ----------------
	logic all_full;
	always_comb begin
		all_full = 1'b1;
		for (int i = 0; i < N; i++) begin
			all_full = all_full && pipe_v_s[i];
		end
	end

	`TBC_ASSERT_IMP(a_ready_only_when_full, clk, arst_n, !s_tready, all_full && !m_tready)
	`TBC_ASSERT_NXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, pipe_v_s[0])
	`TBC_ASSERT_NXT(a_first_holds, clk, arst_n, pipe_v_s[0] && !en[0],
		pipe_v_s[0] && $stable(pipe_d_s[0]))
	`TBC_ASSERT_NXT(a_out_refill, clk, arst_n, m_tvalid && m_tready && pipe_v_s[N-2],
		m_tvalid)

endmodule

`default_nettype wire
